/* rtl/mbss_pkg.sv */
// Package: shared types, codes and constants of the masked byte signature scan.
`timescale 1ns / 1ps
`default_nettype none

package mbss_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_PATTERN_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Pattern bytes held in configuration registers; bytes beyond are wildcards
  localparam int unsigned PAT_REG_BYTES = 16;

  // Relative call / jump decoding
  localparam logic [7:0]  OPC_CALL    = 8'hE8;
  localparam logic [7:0]  OPC_JMP     = 8'hE9;
  localparam logic [63:0] INSN_LEN    = 64'd5;
  localparam int unsigned DISP_BYTES  = 4;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_CARE     = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_BASE     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PAT_REG_BYTES-1:0][7:0] pattern;
    logic [PAT_REG_BYTES-1:0]      care_mask;
    logic [4:0]                    pattern_length;
    logic [63:0]                   section_base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
    logic [63:0] result_address;
  } out_item_t;

  // Control group of the window stage, seen by the match stage
  typedef struct packed {
    logic valid;
    logic last;
    logic span_ok;
  } win_ctl_t;

endpackage

`default_nettype wire

/* rtl/mbss_cfg.sv */
// Configuration register file and effective pattern length.
`timescale 1ns / 1ps
`default_nettype none

module mbss_cfg
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]          cfg_data_i,
  output cfg_t                      cfg_o,
  output logic [LW-1:0]             len_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern: '0, care_mask: '0, pattern_length: 5'd1, section_base: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PAT_LOW:  cfg_q.pattern[7:0]    <= cfg_data_i;
        REG_PAT_HIGH: cfg_q.pattern[15:8]   <= cfg_data_i;
        REG_CARE:     cfg_q.care_mask       <= cfg_data_i[15:0];
        REG_LENGTH:   cfg_q.pattern_length  <= cfg_data_i[4:0];
        REG_BASE:     cfg_q.section_base    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_PATTERN
  always_comb begin
    if (cfg_q.pattern_length == 5'd0) begin
      len_o = LW'(1);
    end else if ({1'b0, cfg_q.pattern_length} > 6'(MAX_PATTERN)) begin
      len_o = LW'(MAX_PATTERN);
    end else begin
      len_o = LW'(cfg_q.pattern_length);
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/mbss_window.sv */
// Input stage: byte window shift register and position count.
`timescale 1ns / 1ps
`default_nettype none

module mbss_window
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire in_item_t                          in_data_i,
  output logic                                   in_stall_o,
  input  wire logic                              adv_i,
  input  wire logic [LW-1:0]                     len_i,
  output win_ctl_t                               ctl_o,
  output logic [MAX_PATTERN-1:0][7:0]            win_o,
  output logic [POSITION_BITS-1:0]               idx_o,
  output logic [POSITION_BITS-1:0]               start_o
);

  logic [MAX_PATTERN-1:0][7:0] win_q, win_d, win_base;
  logic [POSITION_BITS-1:0]    pos_q, pos_d;
  logic [POSITION_BITS-1:0]    idx_q, idx_d, start_q, start_d;
  logic                        clr_q, clr_d;
  win_ctl_t                    ctl_q, ctl_d;
  logic                        in_acc;

  assign in_stall_o = ctl_q.valid && !adv_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    win_base = clr_q ? '0 : win_q;
    win_d    = win_q;
    pos_d    = pos_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    start_d  = start_q;
    ctl_d    = ctl_q;
    if (in_acc) begin
      win_d         = {in_data_i.data_byte, win_base[MAX_PATTERN-1:1]};
      idx_d         = pos_q;
      start_d       = pos_q + POSITION_BITS'(1) - POSITION_BITS'(len_i);
      ctl_d.valid   = 1'b1;
      ctl_d.last    = in_data_i.last_byte;
      ctl_d.span_ok = ({1'b0, pos_q} + (POSITION_BITS + 1)'(1))
                      >= (POSITION_BITS + 1)'(len_i);
      pos_d         = in_data_i.last_byte ? '0 : pos_q + POSITION_BITS'(1);
      clr_d         = in_data_i.last_byte;
    end else if (adv_i) begin
      ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      clr_q   <= 1'b0;
      ctl_q   <= '0;
      idx_q   <= '0;
      start_q <= '0;
    end else begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      clr_q   <= clr_d;
      ctl_q   <= ctl_d;
      idx_q   <= idx_d;
      start_q <= start_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign win_o   = win_q;
  assign idx_o   = idx_q;
  assign start_o = start_q;

endmodule

`default_nettype wire

/* rtl/mbss_match.sv */
// Match stage: window compare, call target, report flags and result register.
`timescale 1ns / 1ps
`default_nettype none

module mbss_match
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1),
  localparam int unsigned KW = $clog2(2 * MAX_PATTERN + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire logic [LW-1:0]          len_i,
  input  wire win_ctl_t               ctl_i,
  input  wire logic [MAX_PATTERN-1:0][7:0] win_i,
  input  wire logic [POSITION_BITS-1:0] idx_i,
  input  wire logic [POSITION_BITS-1:0] start_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output out_item_t                   out_data_o
);

  function automatic logic [7:0] pick(input logic [MAX_PATTERN-1:0][7:0] w,
                                      input logic [KW-1:0] k);
    logic [7:0] r;
    r = 8'h00;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (k == KW'(j)) r = w[j];
    end
    return r;
  endfunction

  logic                     rep_q, rep_d, pend_q, pend_d;
  logic [POSITION_BITS-1:0] moff_q, moff_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;

  logic                     proc, mism, hit, is_call, long_pat, emit;
  logic [7:0]               op;
  logic [KW-1:0]            head, dfirst;
  logic [31:0]              disp;
  logic [POSITION_BITS-1:0] off;
  logic [63:0]              addr, tgt;

  assign adv_o = !out_valid_q || !out_stall_i;
  assign proc  = ctl_i.valid && adv_o;

  always_comb begin
    head = KW'(MAX_PATTERN) - KW'(len_i);
    mism = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < PAT_REG_BYTES && LW'(i) < len_i && cfg_i.care_mask[4'(i)] &&
          pick(win_i, head + KW'(i)) != cfg_i.pattern[4'(i)]) begin
        mism = 1'b1;
      end
    end
    hit      = ctl_i.span_ok && !mism;
    op       = pick(win_i, head);
    is_call  = (op == OPC_CALL) || (op == OPC_JMP);
    long_pat = len_i >= LW'(DISP_BYTES + 1);
    dfirst   = (pend_q || !long_pat) ? KW'(MAX_PATTERN - DISP_BYTES) : head + KW'(1);
    for (int k = 0; k < DISP_BYTES; k++) begin
      disp[k*8 +: 8] = pick(win_i, dfirst + KW'(k));
    end
    off  = pend_q ? moff_q : start_i;
    addr = cfg_i.section_base + 64'(off);
    tgt  = addr + {{32{disp[31]}}, disp} + INSN_LEN;
  end

  always_comb begin
    rep_d       = rep_q;
    pend_d      = pend_q;
    moff_d      = moff_q;
    out_d       = out_q;
    out_valid_d = adv_o ? 1'b0 : out_valid_q;
    emit        = 1'b0;
    if (proc) begin
      if (!rep_q) begin
        if (pend_q) begin
          if (idx_i - moff_q == POSITION_BITS'(DISP_BYTES)) begin
            emit  = 1'b1;
            out_d = '{found: 1'b1, match_address: addr, result_address: tgt};
            rep_d  = 1'b1;
            pend_d = 1'b0;
          end
        end else if (hit) begin
          if (is_call && !long_pat) begin
            moff_d = start_i;
            pend_d = 1'b1;
          end else begin
            emit  = 1'b1;
            rep_d = 1'b1;
            out_d = '{found: 1'b1, match_address: addr,
                      result_address: is_call ? tgt : addr};
          end
        end
      end
      if (ctl_i.last) begin
        if (!rep_q && !emit) begin
          emit  = 1'b1;
          out_d = '0;
          if (pend_d) begin
            out_d = '{found: 1'b1, match_address: addr, result_address: addr};
          end
        end
        rep_d  = 1'b0;
        pend_d = 1'b0;
        moff_d = '0;
      end
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q       <= 1'b0;
      pend_q      <= 1'b0;
      moff_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rep_q       <= rep_d;
      pend_q      <= pend_d;
      moff_q      <= moff_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pend_not_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !rep_q) else $error("pending match after report");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && ctl_i.last |=> !rep_q && !pend_q) else $error("flags kept past section end");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_address == 64'd0 &&
                                    out_q.result_address == 64'd0)
    else $error("not-found result carries an address");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && rep_q && !ctl_i.last |=> !out_valid_q)
    else $error("second report in one section");
`endif

endmodule

`default_nettype wire

/* rtl/masked_byte_signature_scan.sv */
// Top level of the masked byte signature scan.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i) takes one section byte
//   per transfer in address order; last_byte marks the final byte of a section.
// - Output channel (out_valid_o / out_stall_i / out_data_o) gives at most one
//   result per section: the leftmost start where every cared-for pattern byte
//   matches, with the call target when the match opens with E8 or E9 and its
//   displacement ends within the section, or a not-found result on the last byte.
// - Configuration channel (cfg_valid_i / cfg_ready_o) writes pattern, care mask,
//   length and section base; write only while no byte is in flight.
// - Throughput: one byte per cycle while no stalled result is held. The window
//   register feeds one compare stage that writes the result register; the
//   byte-to-byte flags loop through that single stage.
// - Result path: the byte that completes a result is registered in the window
//   register, and the result drawn from it in the result register.
// - Reset: window, position and flags clear at once; pattern length reads 1,
//   all other registers 0. No clearing pass.
// - Stall: a stalled result holds in the output register; the block keeps
//   taking bytes until the match stage holds one too, then raises in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_signature_scan
  import mbss_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]          cfg_data_i
);

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  cfg_t                        cfg;
  logic [LW-1:0]               len_eff;
  win_ctl_t                    win_ctl;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic [POSITION_BITS-1:0]    idx, start;
  logic                        adv;

  // Register file; length is clamped here once for both stages
  mbss_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .len_o      (len_eff)
  );

  // Shift each transferred byte into the window, advance the position
  mbss_window #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .adv_i     (adv),
    .len_i     (len_eff),
    .ctl_o     (win_ctl),
    .win_o     (win),
    .idx_o     (idx),
    .start_o   (start)
  );

  // Compare, decide and hold the result
  mbss_match #(
    .MAX_PATTERN  (MAX_PATTERN),
    .POSITION_BITS(POSITION_BITS)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .len_i      (len_eff),
    .ctl_i      (win_ctl),
    .win_i      (win),
    .idx_i      (idx),
    .start_i    (start),
    .adv_o      (adv),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* bench/masked_byte_signature_scan_tb.sv */
// Self-checking testbench of the masked byte signature scan with a predicting scoreboard.
`timescale 1ns / 1ps

module masked_byte_signature_scan_tb;
  import mbss_pkg::*;

  localparam int WINDOW     = 16;
  localparam int SCAN_BYTES = 1000;

  // Scoreboard: mirrors the scan state per accepted byte and holds the reports
  // the block owes us, oldest first.
  class scan_scoreboard;
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [63:0] base;
    logic [15:0] care;
    logic [4:0]  length;
    logic [7:0]  window [WINDOW];
    logic [31:0] position;
    logic [31:0] hit_offset;
    bit          reported;
    bit          waiting_disp;
    out_item_t   expected_hits [$];
    int          errors;

    function new();
      pat_low  = '0;
      pat_high = '0;
      base     = '0;
      care     = '0;
      length   = 5'd1;
      errors   = 0;
      clear_section();
    endfunction

    function void clear_section();
      for (int i = 0; i < WINDOW; i++) window[i] = 8'h00;
      position     = '0;
      hit_offset   = '0;
      reported     = 1'b0;
      waiting_disp = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_PAT_LOW:  pat_low  = val;
        REG_PAT_HIGH: pat_high = val;
        REG_CARE:     care     = val[15:0];
        REG_LENGTH:   length   = val[4:0];
        REG_BASE:     base     = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int i);
      return (i < 8) ? pat_low[i*8 +: 8] : pat_high[(i-8)*8 +: 8];
    endfunction

    // Zero length scans as one byte, anything past the window as the full window
    function int effective_length();
      if (length == 0) return 1;
      if (length > WINDOW) return WINDOW;
      return int'(length);
    endfunction

    function bit window_hit(int len);
      int first;
      first = WINDOW - len;
      for (int i = 0; i < len; i++)
        if (care[i] && window[first+i] != pattern_byte(i)) return 1'b0;
      return 1'b1;
    endfunction

    // Little-endian rel32 after the opcode, sign extended, plus instruction length
    function logic [63:0] call_target(logic [63:0] addr, int first);
      logic [31:0] disp;
      disp = {window[first+3], window[first+2], window[first+1], window[first]};
      return addr + {{32{disp[31]}}, disp} + INSN_LEN;
    endfunction

    function void push_hit(logic found, logic [63:0] match_addr, logic [63:0] result_addr);
      out_item_t hit;
      hit.found          = found;
      hit.match_address  = match_addr;
      hit.result_address = result_addr;
      expected_hits.push_back(hit);
      reported     = 1'b1;
      waiting_disp = 1'b0;
    endfunction

    // Advance the scan by one accepted byte
    function void take_byte(in_item_t item);
      logic [31:0] idx;
      logic [63:0] start;
      logic [63:0] addr;
      int          len;
      int          first;
      idx = position;
      for (int i = 0; i < WINDOW-1; i++) window[i] = window[i+1];
      window[WINDOW-1] = item.data_byte;
      if (!reported) begin
        if (waiting_disp) begin
          // Displacement complete once four bytes follow the opcode
          if (idx - hit_offset == 32'(DISP_BYTES)) begin
            addr = base + {32'd0, hit_offset};
            push_hit(1'b1, addr, call_target(addr, WINDOW - DISP_BYTES));
          end
        end else begin
          len   = effective_length();
          start = {32'd0, idx} + 64'd1 - 64'(len);
          if ({32'd0, idx} + 64'd1 >= 64'(len) && window_hit(len)) begin
            addr  = base + start;
            first = WINDOW - len;
            if (window[first] == OPC_CALL || window[first] == OPC_JMP) begin
              if (len > DISP_BYTES) begin
                push_hit(1'b1, addr, call_target(addr, first + 1));
              end else begin
                hit_offset   = start[31:0];
                waiting_disp = 1'b1;
              end
            end else begin
              push_hit(1'b1, addr, addr);
            end
          end
        end
      end
      if (item.last_byte) begin
        // Section closes: a short displacement reports the plain address
        if (!reported) begin
          if (waiting_disp) begin
            addr = base + {32'd0, hit_offset};
            push_hit(1'b1, addr, addr);
          end else begin
            push_hit(1'b0, 64'd0, 64'd0);
          end
        end
        clear_section();
      end else begin
        position = idx + 32'd1;
      end
    endfunction

    function void mismatch(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual found=%b match=%h result=%h",
                 $time, got.found, got.match_address, got.result_address);
        return;
      end
      want = expected_hits.pop_front();
      if (got.found !== want.found) mismatch("found", 64'(want.found), 64'(got.found));
      if (got.match_address !== want.match_address)
        mismatch("match_address", want.match_address, got.match_address);
      if (got.result_address !== want.result_address)
        mismatch("result_address", want.result_address, got.result_address);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_e    cfg_index;
  logic [63:0] cfg_data;

  scan_scoreboard sb = new();

  logic [7:0] section_q [$];   // bytes of the section being sent
  int         bytes_sent  = 0;
  int         hold_cycles = 0; // one-shot long stall request for the result side
  bit         send_idle   = 1'b1;
  bit         recv_idle   = 1'b1;

  masked_byte_signature_scan dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // Hold valid and payload until the write transfer; leave valid high for the caller
  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Write every register back to back, then drop the write valid
  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] mask, input logic [63:0] len,
                           input logic [63:0] base);
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, hi);
    write_reg(REG_CARE, mask);
    write_reg(REG_LENGTH, len);
    write_reg(REG_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  // Offer one byte, after a random gap while send_idle is set; hold it unchanged while stalled
  task automatic send_byte(input logic [7:0] data, input logic last);
    int       gap;
    in_item_t item;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = data;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.take_byte(item);
    bytes_sent++;
  endtask

  task automatic send_section();
    for (int j = 0; j < section_q.size(); j++)
      send_byte(section_q[j], j == section_q.size() - 1);
  endtask

  // Drop valid, drain every owed report, then let the last non-reporting byte settle
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Half the noise reuses pattern bytes so near misses and early matches show up
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1)) return sb.pattern_byte($urandom_range(0, WINDOW - 1));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pattern_instance_byte(int i);
    if (sb.care[i]) return sb.pattern_byte(i);
    return 8'($urandom);
  endfunction

  // Mostly noise + full pattern copy + noise; some cut short, some pure noise
  task automatic build_section();
    int kind;
    int span;
    int cut;
    section_q.delete();
    span = sb.effective_length();
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      repeat ($urandom_range(0, 6)) section_q.push_back(noise_byte());
      cut = (kind == 7) ? $urandom_range(1, span) : span;
      for (int i = 0; i < cut; i++) section_q.push_back(pattern_instance_byte(i));
      if (kind < 7) repeat ($urandom_range(0, 6)) section_q.push_back(noise_byte());
    end else begin
      repeat (kind == 8 ? $urandom_range(1, 12) : 1) section_q.push_back(noise_byte());
    end
  endtask

  task automatic random_phase(input int p);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mask;
    logic [63:0] len;
    logic [63:0] base;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    mask = {48'd0, 16'($urandom)};
    len  = 64'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8));
    // First phases sweep the length and care-mask extremes
    case (p)
      0: len = 64'd31;
      1: begin
        len  = 64'd16;
        mask = 64'hFFFF;
      end
      2: len = 64'd0;
      4: mask = 64'd0;
      default: ;
    endcase
    // Open the pattern with a call or jump opcode half the time
    if ($urandom_range(0, 1)) begin
      lo[7:0] = $urandom_range(0, 1) ? OPC_CALL : OPC_JMP;
      mask[0] = 1'b1;
    end
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = '1 - 64'($urandom_range(0, 40));
      2: base = {$urandom, $urandom};
      default: base = 64'($urandom);
    endcase
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    if (p == 3) begin
      // Back-pressure phase: stream without gaps while the result side holds off
      send_idle   = 1'b0;
      hold_cycles = 80;
    end
    configure(lo, hi, mask, len, base);
    repeat ((p == 3) ? 20 : $urandom_range(6, 12)) begin
      build_section();
      send_section();
    end
    end_phase();
  endtask

  // Result side: stall for a drawn count (or a requested long hold), then take
  // the next transfer and check it against the oldest owed report
  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      wait_cycles = (hold_cycles > 0) ? hold_cycles
                                      : (recv_idle ? $urandom_range(0, 12) : 0);
      hold_cycles = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_report(out_data);
    end
  end

  initial begin : stimulus
    int p;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PAT_LOW;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-byte pattern, nothing cared for, so every start matches.
    // Plain report with the rest of the section ignored, a call whose displacement
    // trails the match, and a jump cut off before its displacement is complete.
    section_q = '{8'h00, 8'hFF};
    send_section();
    section_q = '{OPC_CALL, 8'h01, 8'h02, 8'h03, 8'h04};
    send_section();
    section_q = '{OPC_JMP, 8'h10, 8'h20};
    send_section();
    end_phase();

    // Length zero counts as one; base near the top wraps the match address; a
    // one-byte section without the pattern reports not found
    configure(64'h0000_0000_0000_00FF, 64'd0, 64'h1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    section_q = '{8'h00, 8'h7F, 8'hFF, 8'h01};
    send_section();
    section_q = '{8'h00};
    send_section();
    end_phase();

    // Five-byte call pattern with a negative displacement inside the match
    configure(64'h0000_00FF_FFFF_FCE8, '1, 64'h1F, 64'd5, 64'h1000);
    section_q = '{8'h55, OPC_CALL, 8'hFC, 8'hFF, 8'hFF, 8'hFF};
    send_section();
    end_phase();

    p = 0;
    while (bytes_sent < SCAN_BYTES) begin
      random_phase(p);
      p++;
    end

    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/mbss_pkg.sv
rtl/mbss_cfg.sv
rtl/mbss_window.sv
rtl/mbss_match.sv
rtl/masked_byte_signature_scan.sv
bench/masked_byte_signature_scan_tb.sv
